[src/lcps_pkg.sv]
// ----------------------------------------------------------------------------
// lcps_pkg: LED color pattern sequencer package
// Word types and command codes shared by the sequencer and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package lcps_pkg;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_LOAD = 3'd1;
  localparam logic [2:0] KIND_RUN  = 3'd2;
  localparam logic [2:0] KIND_SET  = 3'd3;
  localparam logic [2:0] KIND_OFF  = 3'd4;
  localparam logic [2:0] KIND_STOP = 3'd5;

  localparam logic [15:0] TICKS_MAX  = 16'hFFFF;
  localparam logic [7:0]  PASSES_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
    logic [7:0]  repeat_times;
    logic        forever_req;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       running;
    logic [3:0] step_now;
  } out_word_t;

endpackage

`default_nettype wire

[src/lcps_if.sv]
// ----------------------------------------------------------------------------
// lcps_if: sequencer channel interfaces
// Valid/ready channels for command words in and status words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcps_in_if;
  logic               valid;
  logic               ready;
  lcps_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcps_out_if;
  logic                valid;
  logic                ready;
  lcps_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/led_color_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// led_color_pattern_sequencer: timed RGB pattern player
// Plays stored color/duration steps on millisecond ticks, with load, run,
// set, off and stop commands. One status word per command word.
// A command is registered into in_q first; its status word is registered from the
// state update once the output can take it. Throughput: one word per cycle while the status channel is ready.
// Reset: rst (sync, active high) clears all control state, marks and the
// output color; pattern slots are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module led_color_pattern_sequencer #(
  parameter int MAX_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  lcps_in_if.sink      item,
  lcps_out_if.source   result
);

  // slot field is 4 bits, so at most 16 slots are ever writable
  localparam int DEPTH = (MAX_STEPS < 16) ? MAX_STEPS : 16;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic               in_valid;
  lcps_pkg::in_word_t in_q;
  logic               out_valid;
  logic               adv;

  logic [15:0]    dur_mem [DEPTH];
  lcps_pkg::rgb_t col_mem [DEPTH];

  logic [DEPTH-1:0] marks;
  lcps_pkg::rgb_t   color_now, color_now_next;
  logic             playing, playing_next;
  logic [IW-1:0]    step_index, step_index_next;
  logic [CW-1:0]    pattern_count, pattern_count_next;
  logic [7:0]       pass_target, pass_target_next;
  logic             repeat_always, repeat_always_next;
  logic [7:0]       passes_done, passes_done_next;
  logic [15:0]      elapsed_ticks, elapsed_ticks_next;

  logic [CW-1:0]  len;
  logic [CW-1:0]  step_inc;
  logic           wrap;
  logic [IW-1:0]  next_idx;
  logic [IW-1:0]  rd_idx;
  lcps_pkg::rgb_t rd_col;
  logic [15:0]    cur_dur;
  logic [15:0]    elapsed_inc;
  logic [7:0]     passes_inc;
  logic           slot_ok;

  assign adv        = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q <= item.data;
    end
  end

  // pattern length: first slot without a nonzero duration
  always_comb begin
    len = CW'(DEPTH);
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!marks[k]) begin
        len = CW'(k);
      end
    end
  end

  assign cur_dur     = dur_mem[step_index];
  assign step_inc    = CW'(step_index) + CW'(1);
  assign wrap        = step_inc >= pattern_count;
  assign next_idx    = wrap ? '0 : step_inc[IW-1:0];
  assign rd_idx      = (in_q.kind == lcps_pkg::KIND_RUN) ? '0 : next_idx;
  assign rd_col      = col_mem[rd_idx];
  assign elapsed_inc = (elapsed_ticks == lcps_pkg::TICKS_MAX) ? elapsed_ticks
                                                              : elapsed_ticks + 16'd1;
  assign passes_inc  = (passes_done == lcps_pkg::PASSES_MAX) ? passes_done
                                                             : passes_done + 8'd1;
  assign slot_ok     = int'(in_q.slot) < DEPTH;

  always_comb begin
    color_now_next     = color_now;
    playing_next       = playing;
    step_index_next    = step_index;
    pattern_count_next = pattern_count;
    pass_target_next   = pass_target;
    repeat_always_next = repeat_always;
    passes_done_next   = passes_done;
    elapsed_ticks_next = elapsed_ticks;
    case (in_q.kind)
      lcps_pkg::KIND_TICK: begin
        if (playing) begin
          if (elapsed_inc < cur_dur) begin
            elapsed_ticks_next = elapsed_inc;
          end else begin
            elapsed_ticks_next = '0;
            step_index_next    = next_idx;
            color_now_next     = rd_col;
            if (wrap && !repeat_always) begin
              passes_done_next = passes_inc;
              if (passes_inc >= pass_target) begin
                playing_next   = 1'b0;
                color_now_next = '0;
              end
            end
          end
        end
      end
      lcps_pkg::KIND_RUN: begin
        if (marks[0]) begin
          pattern_count_next = len;
          step_index_next    = '0;
          pass_target_next   = in_q.repeat_times;
          repeat_always_next = in_q.forever_req;
          passes_done_next   = '0;
          elapsed_ticks_next = '0;
          playing_next       = 1'b1;
          color_now_next     = rd_col;
        end
      end
      lcps_pkg::KIND_SET: begin
        playing_next   = 1'b0;
        color_now_next = '{red: in_q.red, green: in_q.green, blue: in_q.blue};
      end
      lcps_pkg::KIND_OFF: begin
        playing_next   = 1'b0;
        color_now_next = '0;
      end
      lcps_pkg::KIND_STOP: begin
        playing_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && in_q.kind == lcps_pkg::KIND_LOAD && slot_ok) begin
      dur_mem[in_q.slot[IW-1:0]] <= in_q.duration;
      col_mem[in_q.slot[IW-1:0]] <= '{red: in_q.red, green: in_q.green, blue: in_q.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      marks         <= '0;
      color_now     <= '0;
      playing       <= 1'b0;
      step_index    <= '0;
      pattern_count <= '0;
      pass_target   <= '0;
      repeat_always <= 1'b0;
      passes_done   <= '0;
      elapsed_ticks <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        if (in_q.kind == lcps_pkg::KIND_LOAD && slot_ok) begin
          marks[in_q.slot[IW-1:0]] <= in_q.duration != 16'd0;
        end
        color_now     <= color_now_next;
        playing       <= playing_next;
        step_index    <= step_index_next;
        pattern_count <= pattern_count_next;
        pass_target   <= pass_target_next;
        repeat_always <= repeat_always_next;
        passes_done   <= passes_done_next;
        elapsed_ticks <= elapsed_ticks_next;
      end
    end
  end

  // state registers double as the status word; they hold until it is taken
  assign result.valid          = out_valid;
  assign result.data.red_out   = color_now.red;
  assign result.data.green_out = color_now.green;
  assign result.data.blue_out  = color_now.blue;
  assign result.data.running   = playing;
  assign result.data.step_now  = 4'(step_index);

endmodule

`default_nettype wire

[src/lcps_checker.sv]
// ----------------------------------------------------------------------------
// lcps_checker: port-level checks for the pattern sequencer
// Watches the command and status channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcps_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input lcps_pkg::in_word_t  item_data,
  input logic                result_valid,
  input logic                result_ready,
  input lcps_pkg::out_word_t result_data
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("status word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled status word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("command not taken with output empty");

  a_off: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_data.kind == lcps_pkg::KIND_OFF)
      ##1 (!result_valid || result_ready)
    |=> result_valid && !result_data.running && result_data.red_out == 8'd0
        && result_data.green_out == 8'd0 && result_data.blue_out == 8'd0)
    else $error("off command did not blank the output");

  a_set: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_data.kind == lcps_pkg::KIND_SET)
      ##1 (!result_valid || result_ready)
    |=> result_valid && !result_data.running
        && result_data.red_out == $past(item_data.red, 2)
        && result_data.green_out == $past(item_data.green, 2)
        && result_data.blue_out == $past(item_data.blue, 2))
    else $error("set command color mismatch");

endmodule

bind led_color_pattern_sequencer lcps_checker u_lcps_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_data    (item.data),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

`default_nettype wire
